// ----- hw/rtl/adccal_pkg.sv -----
package adccal_pkg;

  localparam int unsigned MAX_RESOLUTION_DEF = 32;
  localparam int unsigned CODE_W             = 32;
  localparam int unsigned BITS_W             = 6;
  localparam int unsigned DIV_STAGES         = CODE_W;

  localparam logic [BITS_W-1:0] RESET_BITS = 6'd12;
  localparam logic [CODE_W-1:0] RESET_LOW  = 32'd0;
  localparam logic [CODE_W-1:0] RESET_HIGH = 32'd4095;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_RES_BITS = 2'd0,
    REG_LOW_REF  = 2'd1,
    REG_HIGH_REF = 2'd2
  } reg_idx_t;

  // Word travelling down the divider pipeline
  typedef struct packed {
    logic              byp;     // invalid configuration, pass raw code
    logic              sat;     // clamped result
    logic              direct;  // quotient is the result
    logic [CODE_W-1:0] val;     // result when not direct
    logic [CODE_W-1:0] span;    // divisor
    logic [CODE_W-1:0] rem;     // partial remainder
    logic [CODE_W-1:0] low;     // dividend bits left, quotient shifted in
  } pipe_t;

endpackage

// ----- hw/rtl/adccal_prep.sv -----
module adccal_prep
  import adccal_pkg::*;
#(
  parameter int unsigned MaxResolution = MAX_RESOLUTION_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_v,
  input  logic [CODE_W-1:0] raw,
  input  logic [BITS_W-1:0] res_bits,
  input  logic [CODE_W-1:0] low_ref,
  input  logic [CODE_W-1:0] high_ref,
  output logic              up_ready,
  input  logic              dn_ready,
  output logic              v,
  output pipe_t             pl
);

  typedef struct packed {
    logic              byp;
    logic              sat;
    logic              direct;
    logic [CODE_W-1:0] val;
    logic [CODE_W-1:0] span;
    logic [CODE_W-1:0] d;
    logic [BITS_W-1:0] bits;
  } prep_t;

  logic        va;
  prep_t       pa;
  prep_t       pa_next;
  logic        ready_a;
  logic [CODE_W:0]     fs;
  logic                invalid;
  logic [2*CODE_W-1:0] num;

  // Decode the configuration and classify the raw code
  always_comb begin
    fs      = (33'd1 << res_bits) - 33'd1;
    invalid = (res_bits == '0) || (res_bits > BITS_W'(MaxResolution)) ||
              (high_ref <= low_ref) || ({1'b0, low_ref} >= fs) ||
              ({1'b0, high_ref} > fs);
    pa_next        = '0;
    pa_next.span   = high_ref - low_ref;
    pa_next.d      = raw - low_ref;
    pa_next.bits   = res_bits;
    if (invalid) begin
      pa_next.byp = 1'b1;
      pa_next.val = raw;
    end else if (raw < low_ref) begin
      pa_next.sat = 1'b1;
      pa_next.val = '0;
    end else if ((raw - low_ref) > (high_ref - low_ref)) begin
      pa_next.sat = 1'b1;
      pa_next.val = fs[CODE_W-1:0];
    end else begin
      pa_next.direct = 1'b1;
    end
  end

  assign ready_a  = !v || dn_ready;
  assign up_ready = !va || ready_a;

  // Stage A: hold the classified word
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (up_ready) begin
      va <= in_v;
    end
    if (up_ready) begin
      pa <= pa_next;
    end
  end

  // d * (2^bits - 1) as a shift and a subtract
  assign num = ({{CODE_W{1'b0}}, pa.d} << pa.bits) - {{CODE_W{1'b0}}, pa.d};

  // Stage B: hold the dividend split into remainder and low bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (ready_a) begin
      v <= va;
    end
    if (ready_a) begin
      pl.byp    <= pa.byp;
      pl.sat    <= pa.sat;
      pl.direct <= pa.direct;
      pl.val    <= pa.val;
      pl.span   <= pa.span;
      pl.rem    <= num[2*CODE_W-1:CODE_W];
      pl.low    <= num[CODE_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/adccal_div_stage.sv -----
module adccal_div_stage
  import adccal_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_v,
  input  pipe_t in_pl,
  output logic  up_ready,
  input  logic  dn_ready,
  output logic  v,
  output pipe_t pl
);

  logic [CODE_W:0] trial;
  logic            take;
  pipe_t           pl_next;

  // One restoring division step: one quotient bit
  always_comb begin
    trial   = {in_pl.rem, in_pl.low[CODE_W-1]};
    take    = trial >= {1'b0, in_pl.span};
    pl_next = in_pl;
    pl_next.rem = take ? CODE_W'(trial - {1'b0, in_pl.span}) : trial[CODE_W-1:0];
    pl_next.low = {in_pl.low[CODE_W-2:0], take};
  end

  assign up_ready = !v || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (up_ready) begin
      v <= in_v;
    end
    if (up_ready) begin
      pl <= pl_next;
    end
  end

endmodule

// ----- hw/rtl/adc_two_point_calibration.sv -----
// Channel | Dir | Handshake          | Payload
// in      | in  | in_valid/in_stall  | raw_sample[31:0]
// out     | out | out_valid/out_stall| corrected_sample[31:0], calibration_bypassed, saturated
// cfg     | in  | cfg_valid/cfg_ready| cfg_index[1:0], cfg_data[31:0]
//
// One word per cycle sustained while out_stall is low; two set-up stages,
// 32 divider stages of one quotient bit each and one output stage.
// Synchronous active-high reset empties the pipeline and loads resolution 12,
// low reference 0 and high reference 4095. A stall on the output fills
// empty stages first; in_stall rises only once the stages are all full.
module adc_two_point_calibration
  import adccal_pkg::*;
#(
  parameter int unsigned MaxResolution = MAX_RESOLUTION_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CODE_W-1:0] raw_sample,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] corrected_sample,
  output logic              calibration_bypassed,
  output logic              saturated,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [CODE_W-1:0] cfg_data
);

  logic [BITS_W-1:0] res_bits;
  logic [CODE_W-1:0] low_ref;
  logic [CODE_W-1:0] high_ref;

  logic              sv  [DIV_STAGES+1];
  pipe_t             spl [DIV_STAGES+1];
  logic              srdy[DIV_STAGES+1];
  logic              out_ready;
  logic              prep_ready;
  logic              rnd;
  logic [CODE_W-1:0] q;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      res_bits <= RESET_BITS;
      low_ref  <= RESET_LOW;
      high_ref <= RESET_HIGH;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_RES_BITS: res_bits <= cfg_data[BITS_W-1:0];
        REG_LOW_REF:  low_ref  <= cfg_data;
        REG_HIGH_REF: high_ref <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = !prep_ready;

  adccal_prep #(.MaxResolution(MaxResolution)) u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_v     (in_valid),
    .raw      (raw_sample),
    .res_bits (res_bits),
    .low_ref  (low_ref),
    .high_ref (high_ref),
    .up_ready (prep_ready),
    .dn_ready (srdy[0]),
    .v        (sv[0]),
    .pl       (spl[0])
  );

  // Divider stages
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    adccal_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_v     (sv[i]),
      .in_pl    (spl[i]),
      .up_ready (srdy[i]),
      .dn_ready (srdy[i+1]),
      .v        (sv[i+1]),
      .pl       (spl[i+1])
    );
  end

  assign srdy[DIV_STAGES] = out_ready;

  // Round half up
  assign q   = spl[DIV_STAGES].low;
  assign rnd = {spl[DIV_STAGES].rem, 1'b0} >= {1'b0, spl[DIV_STAGES].span};

  assign out_ready = !out_valid || !out_stall;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= sv[DIV_STAGES];
    end
    if (out_ready) begin
      corrected_sample     <= spl[DIV_STAGES].direct ? q + CODE_W'(rnd)
                                                     : spl[DIV_STAGES].val;
      calibration_bypassed <= spl[DIV_STAGES].byp;
      saturated            <= spl[DIV_STAGES].sat;
    end
  end

endmodule
